[src/tqc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqc_pkg
// shared types and constants of the two-queue replacement cache
// ---------------------------------------------------------------------------
package tqc_pkg;

    localparam int TQC_MAX_ENTRIES  = 16;
    localparam int TQC_KEY_BITS     = 16;
    localparam int TQC_PAYLOAD_BITS = 64;

    localparam int CAP_BITS = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd10;
    localparam int CNT_BITS = 32;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_UNLINK,
        S_UNLINK_END,
        S_COMMIT
    } state_t;

    // write enables toward the entry store
    typedef struct packed {
        logic key_we;
        logic pay_we;
        logic rank_we;
    } tqc_wr_en_t;

endpackage

[src/two_queue_cache_replacement_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_queue_cache_replacement_core
// fully associative cache with simplified two-queue (fifo + lru) replacement
//
// sequencing: clear and unused codes skip the passes; lookup miss and load of a
//   present key take a scan pass only; lookup hit and load of a new key take
//   a scan pass, then a rank update pass when a queue is relinked (one entry
//   store read per cycle)
// throughput: one word at a time; a new word is taken in the cycle done pulses
// reset: queues empty, counters zero, capacity limit 10; results cannot stall
// ---------------------------------------------------------------------------
module two_queue_cache_replacement_core
    import tqc_pkg::*;
#(
    parameter int MAX_ENTRIES  = TQC_MAX_ENTRIES,
    parameter int KEY_BITS     = TQC_KEY_BITS,
    parameter int PAYLOAD_BITS = TQC_PAYLOAD_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    capacity_limit_we,
    input  logic [CAP_BITS-1:0]     capacity_limit,
    // command word
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              action,
    input  logic [KEY_BITS-1:0]     key,
    input  logic [PAYLOAD_BITS-1:0] payload_in,
    // result word
    output logic                    done,
    output logic                    found,
    output logic [PAYLOAD_BITS-1:0] read_data,
    output logic                    evicted,
    output logic [KEY_BITS-1:0]     evicted_key,
    output logic [CNT_BITS-1:0]     hits_seen,
    output logic [CNT_BITS-1:0]     misses_seen
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    // entry counts go up to MAX_ENTRIES itself
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W + 1 > CAP_BITS) ? CNT_W + 1 : CAP_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    // sequencer and pass pipeline
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    p_scan_reg, p_scan_next;
    logic                    p_unl_reg, p_unl_next;
    logic [IDX_W-1:0]        p_idx_reg, p_idx_next;

    // command word and configuration
    logic                    is_load_reg, is_load_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [CAP_BITS-1:0]     cap_reg, cap_next;

    // per-entry flags (promoted = member of lru queue)
    logic [MAX_ENTRIES-1:0]  valid_reg, valid_next;
    logic [MAX_ENTRIES-1:0]  prom_reg, prom_next;
    logic [CNT_BITS-1:0]     hits_reg, hits_next;
    logic [CNT_BITS-1:0]     misses_reg, misses_next;

    // scan results
    logic                    hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]        hit_idx_reg, hit_idx_next;
    logic                    hit_prom_reg, hit_prom_next;
    logic [IDX_W-1:0]        hit_rank_reg, hit_rank_next;
    logic [PAYLOAD_BITS-1:0] hit_pay_reg, hit_pay_next;
    logic [CNT_W-1:0]        cnt_f_reg, cnt_f_next;
    logic [CNT_W-1:0]        cnt_l_reg, cnt_l_next;
    logic                    ff_found_reg, ff_found_next;
    logic [IDX_W-1:0]        ff_idx_reg, ff_idx_next;
    logic [KEY_BITS-1:0]     ff_key_reg, ff_key_next;
    logic                    lf_found_reg, lf_found_next;
    logic [IDX_W-1:0]        lf_idx_reg, lf_idx_next;
    logic [KEY_BITS-1:0]     lf_key_reg, lf_key_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;

    // relink / commit targets
    logic [IDX_W-1:0]        tgt_idx_reg, tgt_idx_next;
    logic                    tgt_prom_reg, tgt_prom_next;
    logic [IDX_W-1:0]        tgt_rank_reg, tgt_rank_next;
    logic [IDX_W-1:0]        slot_idx_reg, slot_idx_next;
    logic                    slot_ok_reg, slot_ok_next;
    logic [IDX_W-1:0]        new_rank_reg, new_rank_next;

    // result word
    logic                    done_reg, done_next;
    logic                    found_reg, found_next;
    logic [PAYLOAD_BITS-1:0] rdata_reg, rdata_next;
    logic                    ev_reg, ev_next;
    logic [KEY_BITS-1:0]     evkey_reg, evkey_next;

    // entry store
    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;
    logic [IDX_W-1:0]        rd_rank;
    tqc_wr_en_t              wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [PAYLOAD_BITS-1:0] wr_payload;
    logic [IDX_W-1:0]        wr_rank;

    // flags of the entry whose store data is back this cycle
    logic                    p_valid;
    logic                    p_prom;
    logic [CMP_W-1:0]        used;
    logic                    need_evict;
    logic [IDX_W-1:0]        victim;

    tqc_store #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .IDX_W        (IDX_W)
    ) u_store (
        .clk        (clk),
        .rd_addr    (idx_reg),
        .rd_key     (rd_key),
        .rd_payload (rd_payload),
        .rd_rank    (rd_rank),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_key     (key_reg),
        .wr_payload (wr_payload),
        .wr_rank    (wr_rank)
    );

    assign p_valid    = valid_reg[p_idx_reg];
    assign p_prom     = prom_reg[p_idx_reg];
    assign used       = CMP_W'(cnt_f_reg) + CMP_W'(cnt_l_reg);
    assign need_evict = (used >= CMP_W'(cap_reg)) || (used >= CMP_W'(MAX_ENTRIES));
    // fifo front first, lru front when the fifo is empty
    assign victim     = ff_found_reg ? ff_idx_reg : lf_idx_reg;

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign read_data   = rdata_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evkey_reg;
    assign hits_seen   = hits_reg;
    assign misses_seen = misses_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            p_scan_reg     <= 1'b0;
            p_unl_reg      <= 1'b0;
            p_idx_reg      <= '0;
            is_load_reg    <= 1'b0;
            key_reg        <= '0;
            pay_reg        <= '0;
            cap_reg        <= CAP_RESET;
            valid_reg      <= '0;
            prom_reg       <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            hit_prom_reg   <= 1'b0;
            hit_rank_reg   <= '0;
            hit_pay_reg    <= '0;
            cnt_f_reg      <= '0;
            cnt_l_reg      <= '0;
            ff_found_reg   <= 1'b0;
            ff_idx_reg     <= '0;
            ff_key_reg     <= '0;
            lf_found_reg   <= 1'b0;
            lf_idx_reg     <= '0;
            lf_key_reg     <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            tgt_idx_reg    <= '0;
            tgt_prom_reg   <= 1'b0;
            tgt_rank_reg   <= '0;
            slot_idx_reg   <= '0;
            slot_ok_reg    <= 1'b0;
            new_rank_reg   <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            rdata_reg      <= '0;
            ev_reg         <= 1'b0;
            evkey_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            p_scan_reg     <= p_scan_next;
            p_unl_reg      <= p_unl_next;
            p_idx_reg      <= p_idx_next;
            is_load_reg    <= is_load_next;
            key_reg        <= key_next;
            pay_reg        <= pay_next;
            cap_reg        <= cap_next;
            valid_reg      <= valid_next;
            prom_reg       <= prom_next;
            hits_reg       <= hits_next;
            misses_reg     <= misses_next;
            hit_found_reg  <= hit_found_next;
            hit_idx_reg    <= hit_idx_next;
            hit_prom_reg   <= hit_prom_next;
            hit_rank_reg   <= hit_rank_next;
            hit_pay_reg    <= hit_pay_next;
            cnt_f_reg      <= cnt_f_next;
            cnt_l_reg      <= cnt_l_next;
            ff_found_reg   <= ff_found_next;
            ff_idx_reg     <= ff_idx_next;
            ff_key_reg     <= ff_key_next;
            lf_found_reg   <= lf_found_next;
            lf_idx_reg     <= lf_idx_next;
            lf_key_reg     <= lf_key_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            tgt_idx_reg    <= tgt_idx_next;
            tgt_prom_reg   <= tgt_prom_next;
            tgt_rank_reg   <= tgt_rank_next;
            slot_idx_reg   <= slot_idx_next;
            slot_ok_reg    <= slot_ok_next;
            new_rank_reg   <= new_rank_next;
            done_reg       <= done_next;
            found_reg      <= found_next;
            rdata_reg      <= rdata_next;
            ev_reg         <= ev_next;
            evkey_reg      <= evkey_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        p_scan_next     = 1'b0;
        p_unl_next      = 1'b0;
        p_idx_next      = idx_reg;
        is_load_next    = is_load_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        cap_next        = cap_reg;
        valid_next      = valid_reg;
        prom_next       = prom_reg;
        hits_next       = hits_reg;
        misses_next     = misses_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_prom_next   = hit_prom_reg;
        hit_rank_next   = hit_rank_reg;
        hit_pay_next    = hit_pay_reg;
        cnt_f_next      = cnt_f_reg;
        cnt_l_next      = cnt_l_reg;
        ff_found_next   = ff_found_reg;
        ff_idx_next     = ff_idx_reg;
        ff_key_next     = ff_key_reg;
        lf_found_next   = lf_found_reg;
        lf_idx_next     = lf_idx_reg;
        lf_key_next     = lf_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        tgt_prom_next   = tgt_prom_reg;
        tgt_rank_next   = tgt_rank_reg;
        slot_idx_next   = slot_idx_reg;
        slot_ok_next    = slot_ok_reg;
        new_rank_next   = new_rank_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        rdata_next      = rdata_reg;
        ev_next         = ev_reg;
        evkey_next      = evkey_reg;

        wr_en           = '0;
        wr_addr         = p_idx_reg;
        wr_payload      = pay_reg;
        wr_rank         = rd_rank - IDX_W'(1);

        if (capacity_limit_we)
        begin
            cap_next = capacity_limit;
        end

        // scan pass: store data for entry p_idx is back this cycle
        if (p_scan_reg)
        begin
            if (p_valid)
            begin
                if (p_prom)
                begin
                    cnt_l_next = cnt_l_reg + CNT_W'(1);
                end
                else
                begin
                    cnt_f_next = cnt_f_reg + CNT_W'(1);
                end
                if (rd_key == key_reg && !hit_found_reg)
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = p_idx_reg;
                    hit_prom_next  = p_prom;
                    hit_rank_next  = rd_rank;
                    hit_pay_next   = rd_payload;
                end
                if (!p_prom && rd_rank == '0 && !ff_found_reg)
                begin
                    ff_found_next = 1'b1;
                    ff_idx_next   = p_idx_reg;
                    ff_key_next   = rd_key;
                end
                if (p_prom && rd_rank == '0 && !lf_found_reg)
                begin
                    lf_found_next = 1'b1;
                    lf_idx_next   = p_idx_reg;
                    lf_key_next   = rd_key;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = p_idx_reg;
            end
        end

        // unlink pass: close the gap behind the target in its queue
        if (p_unl_reg)
        begin
            if (p_idx_reg != tgt_idx_reg && p_valid && p_prom == tgt_prom_reg
                && rd_rank > tgt_rank_reg)
            begin
                wr_en.rank_we = 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next        = key;
                    pay_next        = payload_in;
                    is_load_next    = (action == ACT_LOAD);
                    hit_found_next  = 1'b0;
                    cnt_f_next      = '0;
                    cnt_l_next      = '0;
                    ff_found_next   = 1'b0;
                    lf_found_next   = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    if (action == ACT_LOOKUP || action == ACT_LOAD)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        // clear, or an unused code that only reports
                        if (action == ACT_CLEAR)
                        begin
                            valid_next  = '0;
                            prom_next   = '0;
                            hits_next   = '0;
                            misses_next = '0;
                        end
                        found_next = 1'b0;
                        rdata_next = '0;
                        ev_next    = 1'b0;
                        evkey_next = '0;
                        done_next  = 1'b1;
                    end
                end
            end

            S_SCAN:
            begin
                p_scan_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN_END;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_SCAN_END:
            begin
                state_next = S_DECIDE;
            end

            S_DECIDE:
            begin
                ev_next    = 1'b0;
                evkey_next = '0;
                rdata_next = '0;
                idx_next   = '0;
                if (!is_load_reg)
                begin
                    if (hit_found_reg)
                    begin
                        if (hits_reg != '1)
                        begin
                            hits_next = hits_reg + CNT_BITS'(1);
                        end
                        found_next    = 1'b1;
                        rdata_next    = hit_pay_reg;
                        tgt_idx_next  = hit_idx_reg;
                        tgt_prom_next = hit_prom_reg;
                        tgt_rank_next = hit_rank_reg;
                        slot_idx_next = hit_idx_reg;
                        // lru count taken before the entry leaves its queue
                        if (hit_prom_reg)
                        begin
                            new_rank_next = IDX_W'(cnt_l_reg - CNT_W'(1));
                        end
                        else
                        begin
                            new_rank_next = IDX_W'(cnt_l_reg);
                        end
                        state_next = S_UNLINK;
                    end
                    else
                    begin
                        if (misses_reg != '1)
                        begin
                            misses_next = misses_reg + CNT_BITS'(1);
                        end
                        found_next = 1'b0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (hit_found_reg)
                begin
                    // present key: payload only, queues untouched
                    wr_en.pay_we = 1'b1;
                    wr_addr      = hit_idx_reg;
                    found_next   = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    found_next = 1'b0;
                    if (need_evict && (ff_found_reg || lf_found_reg))
                    begin
                        valid_next[victim] = 1'b0;
                        prom_next[victim]  = 1'b0;
                        ev_next            = 1'b1;
                        evkey_next         = ff_found_reg ? ff_key_reg : lf_key_reg;
                        tgt_idx_next       = victim;
                        tgt_prom_next      = !ff_found_reg;
                        tgt_rank_next      = '0;
                        slot_ok_next       = 1'b1;
                        // lowest free slot once the victim is gone
                        if (free_found_reg && free_idx_reg < victim)
                        begin
                            slot_idx_next = free_idx_reg;
                        end
                        else
                        begin
                            slot_idx_next = victim;
                        end
                        new_rank_next = IDX_W'(cnt_f_reg - CNT_W'(ff_found_reg));
                        state_next    = S_UNLINK;
                    end
                    else
                    begin
                        slot_ok_next  = free_found_reg;
                        slot_idx_next = free_idx_reg;
                        new_rank_next = IDX_W'(cnt_f_reg);
                        state_next    = S_COMMIT;
                    end
                end
            end

            S_UNLINK:
            begin
                p_unl_next = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_UNLINK_END;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_UNLINK_END:
            begin
                state_next = S_COMMIT;
            end

            S_COMMIT:
            begin
                wr_addr = slot_idx_reg;
                wr_rank = new_rank_reg;
                if (is_load_reg)
                begin
                    if (slot_ok_reg)
                    begin
                        wr_en.key_we  = 1'b1;
                        wr_en.pay_we  = 1'b1;
                        wr_en.rank_we = 1'b1;
                        valid_next[slot_idx_reg] = 1'b1;
                        prom_next[slot_idx_reg]  = 1'b0;
                    end
                end
                else
                begin
                    // hit entry goes to the lru tail
                    wr_en.rank_we           = 1'b1;
                    prom_next[slot_idx_reg] = 1'b1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[src/tqc_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tqc_store
// key, payload and queue rank storage with one write port and one
// registered read port
// ---------------------------------------------------------------------------
module tqc_store
    import tqc_pkg::*;
#(
    parameter int MAX_ENTRIES  = TQC_MAX_ENTRIES,
    parameter int KEY_BITS     = TQC_KEY_BITS,
    parameter int PAYLOAD_BITS = TQC_PAYLOAD_BITS,
    parameter int IDX_W        = $clog2(MAX_ENTRIES)
)
(
    input  logic                    clk,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic [KEY_BITS-1:0]     rd_key,
    output logic [PAYLOAD_BITS-1:0] rd_payload,
    output logic [IDX_W-1:0]        rd_rank,
    input  tqc_wr_en_t              wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic [KEY_BITS-1:0]     wr_key,
    input  logic [PAYLOAD_BITS-1:0] wr_payload,
    input  logic [IDX_W-1:0]        wr_rank
);

    logic [KEY_BITS-1:0]     key_mem  [MAX_ENTRIES];
    logic [PAYLOAD_BITS-1:0] pay_mem  [MAX_ENTRIES];
    logic [IDX_W-1:0]        rank_mem [MAX_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en.key_we)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_en.pay_we)
        begin
            pay_mem[wr_addr] <= wr_payload;
        end
        if (wr_en.rank_we)
        begin
            rank_mem[wr_addr] <= wr_rank;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_key     <= key_mem[rd_addr];
        rd_payload <= pay_mem[rd_addr];
        rd_rank    <= rank_mem[rd_addr];
    end

endmodule
